// ----- src/oss_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// oss_pkg: shared types and constants of the order statistics summary
// Holds default sizes, percentile ratio, FSM state type and the control
// structs that travel between the core, the sort cells and the divider.
// ----------------------------------------------------------------------------
package oss_pkg;

  localparam int DEF_CAPACITY    = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  // fraction bits of the mean
  localparam int MEAN_FRAC_BITS = 8;

  // percentile as a ratio: PCT_NUM / PCT_DEN
  localparam int PCT_NUM = 95;
  localparam int PCT_DEN = 100;

  typedef enum logic [0:0] {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_t;

  // broadcast to every sort cell
  typedef struct packed {
    logic insert;  // place the new sample, push larger ones up
    logic shift;   // move every value one cell toward the head
  } cell_ctl_t;

  // divider command
  typedef struct packed {
    logic start;   // load operands and begin
    logic neg;     // negate the quotient at the end
  } div_cmd_t;

endpackage

`default_nettype wire

// ----- src/order_statistics_summary_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// order_statistics_summary_core: streaming min/max/mean/median/p95 summary
// Sorts a set of signed samples in a chain of cells as they arrive and
// reports one summary item when the set is closed.
// ----------------------------------------------------------------------------
// Samples enter one per cycle on the in_ channel. Each present sample is
// placed into a chain of CAPACITY sort cells in the cycle it is accepted, so
// the chain always holds the set in ascending order (equal samples keep
// arrival order), and a running sum is kept beside it. Samples arriving when
// the chain is full are dropped and reported through out_overflow. An item
// with in_last high closes the set: the block then stalls its input while
// the chain shifts its contents out through the head cell, one value per
// cycle, picking off minimum, median (index count/2), 95th percentile
// (index floor(count*95/100), never above count-1) and maximum, and while a
// bit-serial divider forms sum*256/count truncated toward zero. Closing runs
// the count shift steps in the chain alongside the divider, which forms one
// quotient bit per cycle, and then waits, if need be, for the output register
// to empty. The summary sits in an output register, so a new set may start
// while it waits to be taken. An empty set reports all zeros. No clearing
// pass follows reset.
// ----------------------------------------------------------------------------
module order_statistics_summary_core #(
  parameter int CAPACITY    = oss_pkg::DEF_CAPACITY,
  parameter int SAMPLE_BITS = oss_pkg::DEF_SAMPLE_BITS
) (
  input  wire                                                 clk,
  input  wire                                                 rst_n,
  input  wire                                                 in_valid,
  output logic                                                in_stall,
  input  wire signed [SAMPLE_BITS-1:0]                        in_sample,
  input  wire                                                 in_sample_present,
  input  wire                                                 in_last,
  output logic                                                out_valid,
  input  wire                                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]                       out_minimum,
  output logic signed [SAMPLE_BITS-1:0]                       out_maximum,
  output logic signed [SAMPLE_BITS+oss_pkg::MEAN_FRAC_BITS-1:0] out_mean_q8,
  output logic signed [SAMPLE_BITS-1:0]                       out_median,
  output logic signed [SAMPLE_BITS-1:0]                       out_pct95,
  output logic        [$clog2(CAPACITY+1)-1:0]                out_count,
  output logic                                                out_overflow
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int FRAC_W = oss_pkg::MEAN_FRAC_BITS;
  localparam int MEAN_W = SAMPLE_BITS + FRAC_W;
  localparam int NUM_W  = SUM_W + FRAC_W;
  localparam int REM_W  = $clog2(oss_pkg::PCT_DEN);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  oss_pkg::state_t state_r, state_nxt;

  logic        [CNT_W-1:0] count_r, count_nxt;
  logic        [CNT_W-1:0] hi_r, hi_nxt;      // floor(count*95/100)
  logic        [REM_W-1:0] rem_r, rem_nxt;    // count*95 mod 100
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic                    drop_r, drop_nxt;
  logic        [CNT_W-1:0] step_r, step_nxt;  // drain position
  logic                    drained_r, drained_nxt;

  logic signed [SAMPLE_BITS-1:0] min_r, min_nxt;
  logic signed [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic signed [SAMPLE_BITS-1:0] med_r, med_nxt;
  logic signed [SAMPLE_BITS-1:0] pct_r, pct_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_min_r, out_min_nxt;
  logic signed [SAMPLE_BITS-1:0] out_max_r, out_max_nxt;
  logic signed [MEAN_W-1:0]      out_mean_r, out_mean_nxt;
  logic signed [SAMPLE_BITS-1:0] out_med_r, out_med_nxt;
  logic signed [SAMPLE_BITS-1:0] out_pct_r, out_pct_nxt;
  logic        [CNT_W-1:0]       out_count_r, out_count_nxt;
  logic                          out_ovf_r, out_ovf_nxt;

  // --------------------------------------------------------------------------
  // Accumulator update for one accepted item
  // --------------------------------------------------------------------------
  logic                    accept;
  logic                    room;
  logic                    do_insert;
  logic        [CNT_W-1:0] count_acc;
  logic        [CNT_W-1:0] hi_acc;
  logic        [REM_W-1:0] rem_acc;
  logic        [REM_W:0]   rem_sum;
  logic signed [SUM_W-1:0] sum_acc;
  logic                    drop_acc;
  logic        [SUM_W-1:0] sum_mag;

  // hold the input off for the whole drain
  assign in_stall  = state_r != oss_pkg::ST_IDLE;
  assign accept    = in_valid && !in_stall;
  assign room      = count_r < CNT_W'(CAPACITY);
  assign do_insert = accept && in_sample_present && room;
  assign rem_sum   = {1'b0, rem_r} + (REM_W + 1)'(oss_pkg::PCT_NUM);

  always_comb begin
    count_acc = count_r;
    hi_acc    = hi_r;
    rem_acc   = rem_r;
    sum_acc   = sum_r;
    drop_acc  = drop_r;
    if (do_insert) begin
      count_acc = count_r + CNT_W'(1);
      sum_acc   = sum_r + {{(SUM_W - SAMPLE_BITS){in_sample[SAMPLE_BITS-1]}}, in_sample};
      // advance floor(n*95/100) by one step of n
      if (rem_sum >= (REM_W + 1)'(oss_pkg::PCT_DEN)) begin
        rem_acc = REM_W'(rem_sum - (REM_W + 1)'(oss_pkg::PCT_DEN));
        hi_acc  = hi_r + CNT_W'(1);
      end else begin
        rem_acc = rem_sum[REM_W-1:0];
      end
    end
    if (accept && in_sample_present && !room) begin
      drop_acc = 1'b1;
    end
  end

  assign sum_mag = sum_acc[SUM_W-1] ? (~sum_acc + SUM_W'(1)) : sum_acc;

  // --------------------------------------------------------------------------
  // Sort chain
  // --------------------------------------------------------------------------
  oss_pkg::cell_ctl_t            cell_ctl;
  logic signed [SAMPLE_BITS-1:0] cell_val [CAPACITY];
  logic                          cell_gt  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] prev_val;
    logic                          prev_gt;
    logic signed [SAMPLE_BITS-1:0] next_val;

    if (i == 0) begin : g_head
      assign prev_val = in_sample;
      assign prev_gt  = 1'b0;
    end else begin : g_body
      assign prev_val = cell_val[i-1];
      assign prev_gt  = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_val = cell_val[i];
    end else begin : g_link
      assign next_val = cell_val[i+1];
    end

    oss_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .CNT_W       (CNT_W),
      .INDEX       (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .count    (count_r),
      .new_val  (in_sample),
      .prev_val (prev_val),
      .prev_gt  (prev_gt),
      .next_val (next_val),
      .val      (cell_val[i]),
      .gt       (cell_gt[i])
    );
  end

  // --------------------------------------------------------------------------
  // Mean divider
  // --------------------------------------------------------------------------
  oss_pkg::div_cmd_t div_cmd;
  logic              div_busy;
  logic [NUM_W-1:0]  div_quo;

  oss_div #(
    .NUM_W (NUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (div_cmd),
    .num   ({sum_mag, {FRAC_W{1'b0}}}),
    .den   (count_acc),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] last_idx;
  logic [CNT_W-1:0] pct_idx;
  logic             slot_free;
  logic             empty;

  assign last_idx  = count_r - CNT_W'(1);
  assign pct_idx   = (hi_r > last_idx) ? last_idx : hi_r;
  assign slot_free = !out_valid_r || !out_stall;
  assign empty     = count_r == '0;

  always_comb begin
    state_nxt     = state_r;
    cell_ctl      = '0;
    div_cmd       = '0;
    count_nxt     = count_r;
    hi_nxt        = hi_r;
    rem_nxt       = rem_r;
    sum_nxt       = sum_r;
    drop_nxt      = drop_r;
    step_nxt      = step_r;
    drained_nxt   = drained_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    med_nxt       = med_r;
    pct_nxt       = pct_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_min_nxt   = out_min_r;
    out_max_nxt   = out_max_r;
    out_mean_nxt  = out_mean_r;
    out_med_nxt   = out_med_r;
    out_pct_nxt   = out_pct_r;
    out_count_nxt = out_count_r;
    out_ovf_nxt   = out_ovf_r;

    case (state_r)
      oss_pkg::ST_IDLE: begin
        cell_ctl.insert = do_insert;
        count_nxt       = count_acc;
        hi_nxt          = hi_acc;
        rem_nxt         = rem_acc;
        sum_nxt         = sum_acc;
        drop_nxt        = drop_acc;
        if (accept && in_last) begin
          // close the set: start shifting out and dividing
          div_cmd.start = 1'b1;
          div_cmd.neg   = sum_acc[SUM_W-1];
          step_nxt      = '0;
          drained_nxt   = count_acc == '0;
          state_nxt     = oss_pkg::ST_DRAIN;
        end
      end

      oss_pkg::ST_DRAIN: begin
        if (!drained_r) begin
          // pick off order statistics as they pass the head cell
          cell_ctl.shift = 1'b1;
          if (step_r == '0) begin
            min_nxt = cell_val[0];
          end
          if (step_r == (count_r >> 1)) begin
            med_nxt = cell_val[0];
          end
          if (step_r == pct_idx) begin
            pct_nxt = cell_val[0];
          end
          if (step_r == last_idx) begin
            max_nxt     = cell_val[0];
            drained_nxt = 1'b1;
          end
          step_nxt = step_r + CNT_W'(1);
        end else if (!div_busy && slot_free) begin
          // load the summary and clear the set
          out_valid_nxt = 1'b1;
          out_min_nxt   = empty ? '0 : min_r;
          out_max_nxt   = empty ? '0 : max_r;
          out_mean_nxt  = empty ? '0 : div_quo[MEAN_W-1:0];
          out_med_nxt   = empty ? '0 : med_r;
          out_pct_nxt   = empty ? '0 : pct_r;
          out_count_nxt = count_r;
          out_ovf_nxt   = drop_r;
          count_nxt     = '0;
          hi_nxt        = '0;
          rem_nxt       = '0;
          sum_nxt       = '0;
          drop_nxt      = 1'b0;
          state_nxt     = oss_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = oss_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= oss_pkg::ST_IDLE;
      count_r     <= '0;
      hi_r        <= '0;
      rem_r       <= '0;
      sum_r       <= '0;
      drop_r      <= 1'b0;
      step_r      <= '0;
      drained_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      hi_r        <= hi_nxt;
      rem_r       <= rem_nxt;
      sum_r       <= sum_nxt;
      drop_r      <= drop_nxt;
      step_r      <= step_nxt;
      drained_r   <= drained_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    min_r       <= min_nxt;
    max_r       <= max_nxt;
    med_r       <= med_nxt;
    pct_r       <= pct_nxt;
    out_min_r   <= out_min_nxt;
    out_max_r   <= out_max_nxt;
    out_mean_r  <= out_mean_nxt;
    out_med_r   <= out_med_nxt;
    out_pct_r   <= out_pct_nxt;
    out_count_r <= out_count_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_minimum  = out_min_r;
  assign out_maximum  = out_max_r;
  assign out_mean_q8  = out_mean_r;
  assign out_median   = out_med_r;
  assign out_pct95    = out_pct_r;
  assign out_count    = out_count_r;
  assign out_overflow = out_ovf_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("stored count beyond capacity");

  a_pct_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (hi_r < count_r))
    else $error("percentile index outside the stored set");

  a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last) |=> in_stall)
    else $error("input not held off after a closing item");

  a_sorted_summary: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_count != '0) |->
      (out_minimum <= out_median && out_median <= out_pct95 &&
       out_pct95 <= out_maximum))
    else $error("summary order statistics out of order");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_count == '0) |->
      (out_minimum == '0 && out_maximum == '0 && out_mean_q8 == '0))
    else $error("empty set summary not zero");

endmodule

`default_nettype wire

// ----- src/oss_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// oss_cell: one cell of the insertion sort chain
// Holds one sample. On insert it keeps its value, takes the new sample or
// takes its lower neighbor's value; on shift it takes its upper neighbor's.
// ----------------------------------------------------------------------------
module oss_cell #(
  parameter int SAMPLE_BITS = oss_pkg::DEF_SAMPLE_BITS,
  parameter int CNT_W       = 11,
  parameter int INDEX       = 0
) (
  input  wire                           clk,
  input  oss_pkg::cell_ctl_t            ctl,
  input  wire        [CNT_W-1:0]        count,
  input  wire signed [SAMPLE_BITS-1:0]  new_val,
  input  wire signed [SAMPLE_BITS-1:0]  prev_val,
  input  wire                           prev_gt,
  input  wire signed [SAMPLE_BITS-1:0]  next_val,
  output logic signed [SAMPLE_BITS-1:0] val,
  output logic                          gt
);

  logic signed [SAMPLE_BITS-1:0] val_r;
  logic signed [SAMPLE_BITS-1:0] val_nxt;
  logic                          occupied;

  assign occupied = CNT_W'(INDEX) < count;
  // an empty cell counts as larger than any sample
  assign gt  = !occupied || (val_r > new_val);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.shift) begin
      val_nxt = next_val;
    end else if (ctl.insert && gt) begin
      val_nxt = prev_gt ? prev_val : new_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

// ----- src/oss_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// oss_div: restoring divider, one quotient bit per cycle
// Divides an unsigned magnitude by an unsigned divisor and applies the
// requested sign to the quotient.
// ----------------------------------------------------------------------------
module oss_div #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 11
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  oss_pkg::div_cmd_t      cmd,
  input  wire        [NUM_W-1:0] num,
  input  wire        [DEN_W-1:0] den,
  output logic                   busy,
  output logic       [NUM_W-1:0] quo
);

  localparam int ITER_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic              neg_r, neg_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              busy_r, busy_nxt;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    iter_nxt = iter_r;
    busy_nxt = busy_r;
    if (cmd.start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
      neg_nxt  = cmd.neg;
      iter_nxt = ITER_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_nxt  = {quo_r[NUM_W-2:0], ge};
      iter_nxt = iter_r - ITER_W'(1);
      busy_nxt = iter_r != ITER_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
    iter_r <= iter_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;
  assign quo  = neg_r ? (~quo_r + NUM_W'(1)) : quo_r;

endmodule

`default_nettype wire

// ----- sim/tb_order_statistics_summary_core.sv -----
// ----------------------------------------------------------------------------
// tb_order_statistics_summary_core: self-checking bench for the summary core
// Streams sets of signed samples through the core and checks each summary
// item against a predictor that keeps its own sorted copy of the set.
// ----------------------------------------------------------------------------
// A queue of pending items is filled up front: a short directed part (empty
// sets, extreme samples, ties, absent samples), then random sets, mostly
// small with one that overruns the store. A clocked driver offers the items
// with random gaps; a clocked monitor folds each accepted item into the
// predictor and compares each accepted summary field by field with the
// oldest one due. The receiver stalls at random, and twice holds off for a
// long stretch so that the output register fills and the input stalls.
// ----------------------------------------------------------------------------
module tb_order_statistics_summary_core;

  localparam int SB  = oss_pkg::DEF_SAMPLE_BITS;
  localparam int CAP = oss_pkg::DEF_CAPACITY;
  localparam int MW  = SB + oss_pkg::MEAN_FRAC_BITS;
  localparam int CW  = $clog2(CAP + 1);

  localparam int MAX_WAIT   = 12;
  localparam int LONG_HOLD  = 500;
  localparam int DRAIN_WAIT = 64;

  typedef struct packed {
    logic [SB-1:0] sample;
    logic          present;
    logic          last;
  } sample_item_t;

  typedef struct packed {
    logic signed [SB-1:0] minimum;
    logic signed [SB-1:0] maximum;
    logic signed [MW-1:0] mean_q8;
    logic signed [SB-1:0] median;
    logic signed [SB-1:0] pct95;
    logic        [CW-1:0] count;
    logic                 overflow;
  } summary_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic          in_valid = 1'b0;
  logic [SB-1:0] in_sample = '0;
  logic          in_sample_present = 1'b0;
  logic          in_last = 1'b0;
  logic          out_stall = 1'b0;

  wire                 in_stall;
  wire                 out_valid;
  wire signed [SB-1:0] out_minimum;
  wire signed [SB-1:0] out_maximum;
  wire signed [MW-1:0] out_mean_q8;
  wire signed [SB-1:0] out_median;
  wire signed [SB-1:0] out_pct95;
  wire        [CW-1:0] out_count;
  wire                 out_overflow;

  order_statistics_summary_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .in_sample_present (in_sample_present),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_minimum       (out_minimum),
    .out_maximum       (out_maximum),
    .out_mean_q8       (out_mean_q8),
    .out_median        (out_median),
    .out_pct95         (out_pct95),
    .out_count         (out_count),
    .out_overflow      (out_overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // stimulus and expectations
  sample_item_t pending_items[$];
  summary_t     summaries_due[$];
  int           items_made = 0;
  int           err_count = 0;
  int           results_seen = 0;

  // predictor state: the current set in ascending order, its sum, drop flag
  logic signed [SB-1:0] ranked[$];
  longint               set_sum = 0;
  logic                 set_dropped = 1'b0;

  // handshake bookkeeping between the edges
  bit in_took = 0;
  bit rx_took = 0;
  bit tx_busy = 0;
  bit tx_quiet = 0;
  bit rx_quiet = 0;
  int tx_gap = 0;
  int rx_wait = 0;
  int hold_cycles = 0;
  int holds_done = 0;
  summary_t want;

  task automatic report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    err_count++;
  endtask

  task automatic check_field(string name, logic signed [31:0] got,
                             logic signed [31:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("summary %0d %s: got %0d, want %0d",
                                results_seen, name, got, exp_val));
  endtask

  function automatic int pick_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Fold one accepted item into the set; on a closing item, queue its summary.
  task automatic absorb_item(logic [SB-1:0] smp, logic present, logic closing);
    summary_t    s;
    int unsigned n;
    int unsigned hi;
    int unsigned pos;
    longint      q;
    if (present) begin
      if (ranked.size() < CAP) begin
        // ties go after the equal entries already held
        pos = ranked.size();
        while (pos > 0 && ranked[pos-1] > $signed(smp)) pos--;
        ranked.insert(pos, $signed(smp));
        set_sum += $signed(smp);
      end else begin
        set_dropped = 1'b1;
      end
    end
    if (closing) begin
      s = '0;
      n = ranked.size();
      if (n != 0) begin
        s.minimum = ranked[0];
        s.maximum = ranked[n-1];
        q = (set_sum * 256) / longint'(n);
        s.mean_q8 = q[MW-1:0];
        s.median = ranked[n/2];
        hi = (n * oss_pkg::PCT_NUM) / oss_pkg::PCT_DEN;
        if (hi > n - 1) hi = n - 1;
        s.pct95 = ranked[hi];
      end
      s.count = n[CW-1:0];
      s.overflow = set_dropped;
      summaries_due.insert(summaries_due.size(), s);
      ranked.delete();
      set_sum = 0;
      set_dropped = 1'b0;
    end
  endtask

  task automatic queue_item(logic [SB-1:0] smp, logic present, logic closing);
    sample_item_t it;
    it.sample = smp;
    it.present = present;
    it.last = closing;
    pending_items.insert(pending_items.size(), it);
    if (present || closing) items_made++;
  endtask

  // flavor 0: full range, 1: narrow band with many ties, 2: mostly extremes
  function automatic logic [SB-1:0] draw_sample(int flavor);
    case (flavor)
      0: return SB'($urandom);
      1: return SB'(int'($urandom_range(0, 16)) - 8);
      default: begin
        case ($urandom_range(0, 3))
          0: return {1'b1, {(SB-1){1'b0}}};
          1: return {1'b0, {(SB-1){1'b1}}};
          2: return '0;
          default: return SB'($urandom);
        endcase
      end
    endcase
  endfunction

  // Queue one set of n samples with scattered absent items; close it either
  // on the last sample or with a separate absent closing item.
  task automatic queue_set(int n, bit tail_present);
    int flavor;
    flavor = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) queue_item(SB'($urandom), 1'b0, 1'b0);
      queue_item(draw_sample(flavor), 1'b1, tail_present && (i == n - 1));
    end
    if (!(tail_present && n > 0)) queue_item(SB'($urandom), 1'b0, 1'b1);
  endtask

  // Driver: present the next item at the falling edge once the previous one
  // was taken and its gap has run out; hold the payload while stalled.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_took) begin
        tx_busy = 0;
        if ($urandom_range(0, 49) == 0) tx_quiet = !tx_quiet;
        tx_gap = pick_wait(tx_quiet);
      end
      if (!tx_busy) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_sample <= pending_items[0].sample;
          in_sample_present <= pending_items[0].present;
          in_last <= pending_items[0].last;
          void'(pending_items.pop_front());
          in_valid <= 1'b1;
          tx_busy = 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: a random wait after each summary taken, plus long holds.
  always @(negedge clk) begin
    if (rst_n) begin
      if (rx_took) begin
        if ($urandom_range(0, 49) == 0) rx_quiet = !rx_quiet;
        rx_wait = pick_wait(rx_quiet);
      end
      if (rx_wait != 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (hold_cycles != 0);
      end
    end
  end

  // Long hold-off: arm twice, early on and later, while the sender keeps going.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_cycles != 0) begin
        hold_cycles <= hold_cycles - 1;
      end else if ((holds_done == 0 && results_seen >= 3) ||
                   (holds_done == 1 && results_seen >= 30)) begin
        hold_cycles <= LONG_HOLD;
        holds_done <= holds_done + 1;
      end
    end
  end

  // Monitor: sample both handshakes at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      in_took = in_valid && !in_stall;
      if (in_took) absorb_item(in_sample, in_sample_present, in_last);
      rx_took = out_valid && !out_stall;
      if (rx_took) begin
        results_seen++;
        if (summaries_due.size() == 0) begin
          report_mismatch($sformatf("summary %0d arrived with none due", results_seen));
        end else begin
          want = summaries_due.pop_front();
          check_field("minimum", out_minimum, want.minimum);
          check_field("maximum", out_maximum, want.maximum);
          check_field("mean_q8", out_mean_q8, want.mean_q8);
          check_field("median", out_median, want.median);
          check_field("pct95", out_pct95, want.pct95);
          check_field("count", {1'b0, out_count}, {1'b0, want.count});
          check_field("overflow", {1'b0, out_overflow}, {1'b0, want.overflow});
        end
      end
    end
  end

  initial begin
    int  sets_made;
    bit  big_done;
    int  n;

    // empty sets, one with all sample bits set
    queue_item(16'h1234, 1'b0, 1'b1);
    queue_item(16'hffff, 1'b0, 1'b1);
    // single extremes, one closed by an absent item
    queue_item(16'h8000, 1'b1, 1'b1);
    queue_item(16'h7fff, 1'b1, 1'b0);
    queue_item(16'h0000, 1'b0, 1'b1);
    // ties and extremes with an absent item in the middle
    queue_item(16'h7fff, 1'b1, 1'b0);
    queue_item(16'h8000, 1'b1, 1'b0);
    queue_item(16'h0005, 1'b1, 1'b0);
    queue_item(16'h0005, 1'b1, 1'b0);
    queue_item(16'hffff, 1'b1, 1'b0);
    queue_item(16'habcd, 1'b0, 1'b0);
    queue_item(16'h8000, 1'b1, 1'b0);
    queue_item(16'h0005, 1'b1, 1'b1);
    // negative mean that must truncate toward zero
    queue_item(16'hffff, 1'b1, 1'b0);
    queue_item(16'hffff, 1'b1, 1'b0);
    queue_item(16'h0000, 1'b1, 1'b1);
    // two samples
    queue_item(16'h0001, 1'b1, 1'b0);
    queue_item(16'h0002, 1'b1, 1'b1);

    // random sets, mostly small; one overruns the store and drops on close
    sets_made = 0;
    big_done = 0;
    while (items_made < 2000 || sets_made < 50) begin
      if (!big_done && sets_made == 20) begin
        queue_set(CAP + 3, 1'b1);
        big_done = 1;
      end else begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 40);
        queue_set(n, $urandom_range(0, 1));
      end
      sets_made++;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain: all items taken, all summaries in, then a short quiet spell
    while (pending_items.size() != 0 || tx_busy) @(posedge clk);
    while (summaries_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_count == 0 && summaries_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #800000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
